@@ design/dcdft_pkg.sv @@
`timescale 1ns / 1ps

package dcdft_pkg;

  localparam int OUT_W     = 24;
  localparam int INDEX_W   = 6;
  localparam int FRAC_BITS = 15;

  typedef enum logic [2:0] {
    S_LOAD,
    S_MAC,
    S_DRAIN,
    S_DIV_INIT,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load_write;
    logic bin_start;
    logic mac_issue;
    logic post_start;
    logic div_init;
    logic div_step;
    logic out_load;
    logic inverse;
  } cmd_t;

  typedef struct packed {
    logic load_last;
    logic n_last;
    logic pipe_busy;
    logic k_last;
  } status_t;

endpackage

@@ design/dcdft_ctrl.sv @@
`timescale 1ns / 1ps

module dcdft_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  logic                cfg_write,
  input  logic                cfg_data,
  output dcdft_pkg::cmd_t     cmd,
  input  dcdft_pkg::status_t  status
);
  import dcdft_pkg::*;

  state_t state;
  state_t state_next;
  logic   inverse_mode;
  logic   frame_inverse;
  logic   out_valid_next;
  logic   in_accept;
  logic   out_free;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      inverse_mode  <= 1'b0;
      frame_inverse <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (cfg_write) begin
        inverse_mode <= cfg_data;
      end
      // The direction only counts as it stands when the last sample of a frame arrives.
      if (in_accept && status.load_last) begin
        frame_inverse <= inverse_mode;
      end
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.inverse    = frame_inverse;
    state_next     = state;
    in_stall       = 1'b1;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      S_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_write = 1'b1;
          if (status.load_last) begin
            cmd.bin_start = 1'b1;
            state_next    = S_MAC;
          end
        end
      end
      S_MAC: begin
        cmd.mac_issue = 1'b1;
        if (status.n_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status.pipe_busy) begin
          cmd.post_start = 1'b1;
          state_next     = frame_inverse ? S_DIV_INIT : S_EMIT;
        end
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        state_next   = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          if (status.k_last) begin
            state_next = S_LOAD;
          end else begin
            cmd.bin_start = 1'b1;
            state_next    = S_MAC;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  a_load_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |-> !status.pipe_busy)
    else $error("multiply pipeline still busy while loading samples");

  a_div_only_inverse: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) || (state == S_DIV_INIT) |-> frame_inverse)
    else $error("divider running on a forward frame");

  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result raised without a load of the output register");

  a_frame_end_loads: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load && status.k_last |=> !in_stall)
    else $error("block not ready for samples after the last bin");

endmodule

@@ design/dcdft_datapath.sv @@
`timescale 1ns / 1ps

module dcdft_datapath #(
  parameter int POINTS      = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  dcdft_pkg::cmd_t                          cmd,
  output dcdft_pkg::status_t                       status,
  input  logic signed [SAMPLE_BITS-1:0]            sample_real,
  input  logic signed [SAMPLE_BITS-1:0]            sample_imag,
  output logic signed [dcdft_pkg::OUT_W-1:0]       bin_real,
  output logic signed [dcdft_pkg::OUT_W-1:0]       bin_imag,
  output logic        [dcdft_pkg::INDEX_W-1:0]     bin_index,
  output logic                                     last_bin
);
  import dcdft_pkg::*;

  localparam int TW_W      = 16;
  localparam int IDX_W     = $clog2(POINTS);
  localparam int PROD_W    = SAMPLE_BITS + TW_W;
  localparam int ACC_W     = SAMPLE_BITS + TW_W + 1 + $clog2(POINTS);
  localparam int R_W       = ACC_W - FRAC_BITS;
  localparam int Y_W       = R_W + 2;
  localparam int Q_W       = Y_W + 1;
  localparam int DIVISOR   = 2 * POINTS;
  localparam int RB        = $clog2(DIVISOR);
  localparam int DIV_SHIFT = Y_W + RB;
  localparam int RECIP_W   = Y_W + 1;
  localparam int MUL_W     = Y_W + RECIP_W;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] N64     = 64'(POINTS);
  localparam logic [63:0] FOUR_N  = 64'(4 * POINTS);
  localparam logic [63:0] COS_DIV [8] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                          64'd90, 64'd132, 64'd182, 64'd240};
  localparam logic [63:0] SIN_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                          64'd110, 64'd156, 64'd210, 64'd272};

  localparam logic [IDX_W-1:0]        LAST_IDX   = IDX_W'(POINTS - 1);
  localparam logic [IDX_W:0]          PTS        = (IDX_W + 1)'(POINTS);
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC_BITS - 1));
  localparam logic signed [Y_W-1:0]   Y_OFFSET   = Y_W'(POINTS);
  localparam logic [Y_W-1:0]          NEG_FIX    = Y_W'(DIVISOR);
  // Rounded-up reciprocal; exact floor division for every Y_W-bit magnitude.
  localparam logic [RECIP_W-1:0]      RECIP      =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR));
  localparam logic signed [OUT_W-1:0] OUT_MAX    = 24'sh7FFFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN    = -24'sh800000;

  // Alternating Taylor series in Q30, used only while the twiddle table is built.
  function automatic logic [63:0] taylor_q30(input logic [63:0] first,
                                             input logic [63:0] x2,
                                             input logic odd);
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    pos  = first;
    neg  = '0;
    term = first;
    for (int i = 0; i < 8; i++) begin
      if (odd) begin
        term = ((term * x2) >> 30) / SIN_DIV[i];
      end else begin
        term = ((term * x2) >> 30) / COS_DIV[i];
      end
      if (i[0]) begin
        pos = pos + term;
      end else begin
        neg = neg + term;
      end
    end
    return pos - neg;
  endfunction

  function automatic logic signed [TW_W-1:0] q30_to_q15(input logic [63:0] v);
    logic [63:0] q;
    q = (v + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return q[TW_W-1:0];
  endfunction

  // The angle is folded into the first octant and the signs and swap restored afterwards.
  function automatic logic [2*TW_W-1:0] tw_entry(input int idx);
    logic [63:0] m;
    logic [63:0] a;
    logic [63:0] x;
    logic [63:0] x2;
    logic sneg;
    logic cneg;
    logic swap;
    logic signed [TW_W-1:0] c;
    logic signed [TW_W-1:0] s;
    logic signed [TW_W-1:0] t;
    m    = 64'(idx);
    sneg = 1'b0;
    cneg = 1'b0;
    swap = 1'b0;
    if (2 * m > N64) begin
      m    = N64 - m;
      sneg = 1'b1;
    end
    a = 8 * m;
    if (a > 2 * N64) begin
      a    = 4 * N64 - a;
      cneg = 1'b1;
    end
    if (a > N64) begin
      a    = 2 * N64 - a;
      swap = 1'b1;
    end
    x  = (PI_Q30 * a + 2 * N64) / FOUR_N;
    x2 = (x * x) >> 30;
    c  = q30_to_q15(taylor_q30(ONE_Q30, x2, 1'b0));
    s  = q30_to_q15(taylor_q30(x, x2, 1'b1));
    if (swap) begin
      t = c;
      c = s;
      s = t;
    end
    if (cneg) begin
      c = -c;
    end
    if (sneg) begin
      s = -s;
    end
    return {c, s};
  endfunction

  logic signed [TW_W-1:0] tw_cos_rom [POINTS];
  logic signed [TW_W-1:0] tw_sin_rom [POINTS];

  for (genvar g = 0; g < POINTS; g++) begin : g_twiddle
    localparam logic [2*TW_W-1:0] ENTRY = tw_entry(g);
    assign tw_cos_rom[g] = ENTRY[2*TW_W-1:TW_W];
    assign tw_sin_rom[g] = ENTRY[TW_W-1:0];
  end

  logic [2*SAMPLE_BITS-1:0] store [POINTS];

  logic [IDX_W-1:0] load_count;
  logic [IDX_W-1:0] n_cnt;
  logic [IDX_W-1:0] m_cnt;
  logic [IDX_W-1:0] k_cnt;
  logic [IDX_W:0]   m_sum;
  logic             v0;
  logic             v1;

  logic signed [SAMPLE_BITS-1:0] xr;
  logic signed [SAMPLE_BITS-1:0] xi;
  logic signed [TW_W-1:0]        wr;
  logic signed [TW_W-1:0]        wi;
  logic signed [PROD_W-1:0]      p_rr;
  logic signed [PROD_W-1:0]      p_ii;
  logic signed [PROD_W-1:0]      p_ri;
  logic signed [PROD_W-1:0]      p_ir;
  logic signed [ACC_W-1:0]       acc_re;
  logic signed [ACC_W-1:0]       acc_im;
  logic signed [ACC_W-1:0]       rnd_re;
  logic signed [ACC_W-1:0]       rnd_im;
  logic signed [R_W-1:0]         r_re;
  logic signed [R_W-1:0]         r_im;

  logic signed [Y_W-1:0] y_re;
  logic signed [Y_W-1:0] y_im;
  logic [Y_W-1:0]        u_re;
  logic [Y_W-1:0]        u_im;
  logic [MUL_W-1:0]      prod_re;
  logic [MUL_W-1:0]      prod_im;
  logic [Y_W-1:0]        quo_re;
  logic [Y_W-1:0]        quo_im;
  logic                  neg_re;
  logic                  neg_im;

  logic signed [Q_W-1:0] q_re;
  logic signed [Q_W-1:0] q_im;
  logic signed [Q_W-1:0] fin_re;
  logic signed [Q_W-1:0] fin_im;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [Q_W-1:0] v);
    if (v > OUT_MAX) begin
      return OUT_MAX;
    end else if (v < OUT_MIN) begin
      return OUT_MIN;
    end
    return OUT_W'(v);
  endfunction

  assign status.load_last = (load_count == LAST_IDX);
  assign status.n_last    = (n_cnt == LAST_IDX);
  assign status.k_last    = (k_cnt == LAST_IDX);
  assign status.pipe_busy = v0 || v1;

  // Twiddle index k*n mod POINTS is stepped by k for each new n.
  assign m_sum = {1'b0, m_cnt} + {1'b0, k_cnt};

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      n_cnt      <= '0;
      m_cnt      <= '0;
      k_cnt      <= '0;
      v0         <= 1'b0;
      v1         <= 1'b0;
    end else begin
      v0 <= cmd.mac_issue;
      v1 <= v0;
      if (cmd.load_write) begin
        load_count <= status.load_last ? '0 : load_count + 1'b1;
      end
      if (cmd.bin_start) begin
        n_cnt <= '0;
        m_cnt <= '0;
      end else if (cmd.mac_issue) begin
        n_cnt <= n_cnt + 1'b1;
        m_cnt <= (m_sum >= PTS) ? IDX_W'(m_sum - PTS) : m_sum[IDX_W-1:0];
      end
      if (cmd.out_load) begin
        k_cnt <= status.k_last ? '0 : k_cnt + 1'b1;
      end
    end
  end

  // Sample store and twiddle fetch, then products, then accumulation.
  always_ff @(posedge clk) begin
    if (cmd.load_write) begin
      store[load_count] <= {sample_real, sample_imag};
    end
    if (cmd.mac_issue) begin
      {xr, xi} <= store[n_cnt];
      wr       <= tw_cos_rom[m_cnt];
      wi       <= cmd.inverse ? tw_sin_rom[m_cnt] : -tw_sin_rom[m_cnt];
    end
    p_rr <= xr * wr;
    p_ii <= xi * wi;
    p_ri <= xr * wi;
    p_ir <= xi * wr;
    if (cmd.bin_start) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (v1) begin
      acc_re <= acc_re + ACC_W'(p_rr) - ACC_W'(p_ii);
      acc_im <= acc_im + ACC_W'(p_ri) + ACC_W'(p_ir);
    end
  end

  assign rnd_re = acc_re + ROUND_HALF;
  assign rnd_im = acc_im + ROUND_HALF;

  // Inverse scaling is floor((2r + POINTS) / (2 * POINTS)), done on the magnitude.
  assign y_re    = $signed({r_re[R_W-1], r_re, 1'b0}) + Y_OFFSET;
  assign y_im    = $signed({r_im[R_W-1], r_im, 1'b0}) + Y_OFFSET;
  assign prod_re = MUL_W'(u_re) * MUL_W'(RECIP);
  assign prod_im = MUL_W'(u_im) * MUL_W'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.post_start) begin
      r_re <= R_W'(rnd_re >>> FRAC_BITS);
      r_im <= R_W'(rnd_im >>> FRAC_BITS);
    end
    if (cmd.div_init) begin
      neg_re <= y_re[Y_W-1];
      neg_im <= y_im[Y_W-1];
      u_re   <= y_re[Y_W-1] ? (~y_re + NEG_FIX) : y_re;
      u_im   <= y_im[Y_W-1] ? (~y_im + NEG_FIX) : y_im;
    end
    if (cmd.div_step) begin
      quo_re <= Y_W'(prod_re >> DIV_SHIFT);
      quo_im <= Y_W'(prod_im >> DIV_SHIFT);
    end
  end

  assign q_re   = neg_re ? -$signed({1'b0, quo_re}) : $signed({1'b0, quo_re});
  assign q_im   = neg_im ? -$signed({1'b0, quo_im}) : $signed({1'b0, quo_im});
  assign fin_re = cmd.inverse ? q_re : Q_W'(r_re);
  assign fin_im = cmd.inverse ? q_im : Q_W'(r_im);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      bin_real  <= sat_out(fin_re);
      bin_imag  <= sat_out(fin_im);
      bin_index <= INDEX_W'(k_cnt);
      last_bin  <= status.k_last;
    end
  end

endmodule

@@ design/direct_complex_dft_core.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// samples   in         in_valid / in_stall  sample_real, sample_imag
// bins      out        out_valid/out_stall  bin_real, bin_imag, bin_index, last_bin
// config    in         cfg_write            cfg_data (inverse_mode)
//
// Samples are taken one a cycle until a frame of POINTS is held in the sample store.
// Each bin then runs the single complex multiply-accumulate over the whole frame, then
// pipeline drain, rounding and output load; an inverse frame adds, for each bin, the
// divide by POINTS, done as a multiply by a constant reciprocal.
// The next bin is computed while the previous one waits in the output register.
// Reset is synchronous and needs no clearing pass; the sample store is never read
// before a whole frame has been written.

module direct_complex_dft_core #(
  parameter int POINTS      = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [SAMPLE_BITS-1:0]        sample_real,
  input  logic signed [SAMPLE_BITS-1:0]        sample_imag,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [dcdft_pkg::OUT_W-1:0]   bin_real,
  output logic signed [dcdft_pkg::OUT_W-1:0]   bin_imag,
  output logic        [dcdft_pkg::INDEX_W-1:0] bin_index,
  output logic                                 last_bin,
  input  logic                                 cfg_write,
  input  logic                                 cfg_data
);
  import dcdft_pkg::*;

  cmd_t    cmd;
  status_t status;

  dcdft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

  dcdft_datapath #(
    .POINTS      (POINTS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .sample_real (sample_real),
    .sample_imag (sample_imag),
    .bin_real    (bin_real),
    .bin_imag    (bin_imag),
    .bin_index   (bin_index),
    .last_bin    (last_bin)
  );

endmodule

@@ dv/tb_direct_complex_dft_core.sv @@
`timescale 1ns / 1ps

module tb_direct_complex_dft_core;
  import dcdft_pkg::*;

  localparam int POINTS = 64;
  localparam int SAMPLE_BITS = 16;
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;
  localparam int IDLE_PCT = 26;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_FRAMES = 3;

  typedef enum int {PAT_NYQUIST, PAT_IMPULSE, PAT_FULL, PAT_SMALL, PAT_EXTREME} pattern_e;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
  } sample_t;

  typedef struct {
    logic signed [OUT_W-1:0] re;
    logic signed [OUT_W-1:0] im;
    logic [INDEX_W-1:0] idx;
    logic last;
  } bin_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_BITS-1:0] sample_real = '0;
  logic signed [SAMPLE_BITS-1:0] sample_imag = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [OUT_W-1:0] bin_real;
  logic signed [OUT_W-1:0] bin_imag;
  logic [INDEX_W-1:0] bin_index;
  logic last_bin;
  logic cfg_write = 1'b0;
  logic cfg_data = 1'b0;

  direct_complex_dft_core #(
    .POINTS(POINTS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample_real(sample_real),
    .sample_imag(sample_imag),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .bin_real(bin_real),
    .bin_imag(bin_imag),
    .bin_index(bin_index),
    .last_bin(last_bin),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Predictor state: twiddle table, the frame being loaded and the transform direction.
  int cos_q15[POINTS];
  int sin_q15[POINTS];
  logic signed [SAMPLE_BITS-1:0] frame_re[POINTS];
  logic signed [SAMPLE_BITS-1:0] frame_im[POINTS];
  int frame_fill = 0;
  bit pred_inverse = 1'b0;

  sample_t pending_samples[$];
  bin_t expected_bins[$];
  sample_t next_sample;
  bin_t want_bin;

  int errors = 0;
  int bins_checked = 0;
  int forward_frames = 0;
  int inverse_frames = 0;
  int quiet_cycles = 0;
  bit steady = 1'b0;

  function automatic longint unsigned series_q30(longint unsigned first,
                                                 longint unsigned x2,
                                                 longint unsigned j0);
    longint unsigned pos, neg, term, j;
    pos = first;
    neg = 0;
    term = first;
    j = j0;
    for (int i = 0; i < 8; i++) begin
      term = ((term * x2) >> 30) / ((j + 1) * (j + 2));
      j += 2;
      if (i % 2 == 1) pos += term;
      else neg += term;
    end
    return pos - neg;
  endfunction

  function automatic int to_q15(longint unsigned v);
    longint unsigned q;
    q = (v + (64'd1 << 14)) >> 15;
    return (q > 32767) ? 32767 : int'(q);
  endfunction

  // The angle is folded into the first octant, so only that range is ever evaluated.
  function automatic void build_twiddles();
    longint unsigned m, a, x, x2;
    int c, s, t;
    bit sneg, cneg, swap;
    for (int idx = 0; idx < POINTS; idx++) begin
      m = idx;
      sneg = 1'b0;
      cneg = 1'b0;
      swap = 1'b0;
      if (2 * m > POINTS) begin
        m = POINTS - m;
        sneg = 1'b1;
      end
      a = 8 * m;
      if (a > 2 * POINTS) begin
        a = 4 * POINTS - a;
        cneg = 1'b1;
      end
      if (a > POINTS) begin
        a = 2 * POINTS - a;
        swap = 1'b1;
      end
      x = (PI_Q30 * a + 2 * POINTS) / (4 * POINTS);
      x2 = (x * x) >> 30;
      c = to_q15(series_q30(ONE_Q30, x2, 0));
      s = to_q15(series_q30(x, x2, 1));
      if (swap) begin
        t = c;
        c = s;
        s = t;
      end
      cos_q15[idx] = cneg ? -c : c;
      sin_q15[idx] = sneg ? -s : s;
    end
  endfunction

  // Round half up: floor(v / d + 1/2) with d positive.
  function automatic longint round_half_up(longint v, longint d);
    longint y, d2;
    y = 2 * v + d;
    d2 = 2 * d;
    if (y >= 0) return y / d2;
    return -((-y + d2 - 1) / d2);
  endfunction

  function automatic longint clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic void load_sample(sample_t smp);
    longint acc_re, acc_im, xr, xi, wr, wi;
    int m;
    bin_t b;
    frame_re[frame_fill] = smp.re;
    frame_im[frame_fill] = smp.im;
    frame_fill++;
    if (frame_fill < POINTS) return;
    frame_fill = 0;
    if (pred_inverse) inverse_frames++;
    else forward_frames++;
    for (int k = 0; k < POINTS; k++) begin
      acc_re = 0;
      acc_im = 0;
      for (int n = 0; n < POINTS; n++) begin
        m = (k * n) % POINTS;
        wr = cos_q15[m];
        wi = pred_inverse ? longint'(sin_q15[m]) : -longint'(sin_q15[m]);
        xr = longint'(frame_re[n]);
        xi = longint'(frame_im[n]);
        acc_re += xr * wr - xi * wi;
        acc_im += xr * wi + xi * wr;
      end
      acc_re = round_half_up(acc_re, 32768);
      acc_im = round_half_up(acc_im, 32768);
      if (pred_inverse) begin
        acc_re = round_half_up(acc_re, POINTS);
        acc_im = round_half_up(acc_im, POINTS);
      end
      b.re = OUT_W'(clamp24(acc_re));
      b.im = OUT_W'(clamp24(acc_im));
      b.idx = INDEX_W'(k);
      b.last = (k == POINTS - 1);
      expected_bins.push_back(b);
    end
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_value(pattern_e pat, int n, bit imag);
    logic signed [SAMPLE_BITS-1:0] corners[5];
    corners = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
    case (pat)
      PAT_NYQUIST: begin
        return ((n % 2 == 0) ^ imag) ? 16'sd32767 : -16'sd32768;
      end
      PAT_IMPULSE: begin
        if (n != 0) return 16'sd0;
        return imag ? 16'sd32767 : -16'sd32768;
      end
      PAT_SMALL: begin
        return SAMPLE_BITS'($signed($urandom_range(0, 8)) - 4);
      end
      PAT_EXTREME: begin
        return corners[$urandom_range(0, 4)];
      end
      default: begin
        return SAMPLE_BITS'($urandom);
      end
    endcase
  endfunction

  // Waits until every sample is taken and every bin has come back, then sets the
  // direction and queues the next frame.
  task automatic queue_frame(bit inverse, pattern_e pat);
    sample_t smp;
    while (pending_samples.size() != 0 || in_valid || expected_bins.size() != 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= inverse;
    @(posedge clk);
    cfg_write <= 1'b0;
    pred_inverse = inverse;
    @(negedge clk);
    for (int n = 0; n < POINTS; n++) begin
      smp.re = pick_value(pat, n, 1'b0);
      smp.im = pick_value(pat, n, 1'b1);
      pending_samples.push_back(smp);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        next_sample.re = sample_real;
        next_sample.im = sample_imag;
        load_sample(next_sample);
      end
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_sample = pending_samples.pop_front();
          in_valid <= 1'b1;
          sample_real <= next_sample.re;
          sample_imag <= next_sample.im;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bins.size() == 0) begin
          $error("bin %0d arrived with no bin expected", bin_index);
          errors++;
        end else begin
          want_bin = expected_bins.pop_front();
          check_field("bin_real", want_bin.re, bin_real);
          check_field("bin_imag", want_bin.im, bin_imag);
          check_field("bin_index", want_bin.idx, bin_index);
          check_field("last_bin", want_bin.last, last_bin);
          bins_checked++;
        end
      end
      out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Nothing moved for %0d cycles.", WATCHDOG_LIMIT);
        $display("tb_direct_complex_dft_core NOT OK");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    build_twiddles();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Full-scale alternating samples forward, then a full-scale impulse inverse.
    queue_frame(1'b0, PAT_NYQUIST);
    queue_frame(1'b1, PAT_IMPULSE);

    for (int f = 0; f < RANDOM_FRAMES; f++) begin
      queue_frame(1'($urandom_range(0, 1)), pattern_e'(PAT_FULL + (f % 3)));
      steady = (f == 1);
    end

    while (pending_samples.size() != 0 || in_valid || expected_bins.size() != 0)
      @(negedge clk);
    steady = 1'b0;
    repeat (300) @(posedge clk);

    $display("Ran %0d forward and %0d inverse frames of %0d samples; %0d bins checked.",
             forward_frames, inverse_frames, POINTS, bins_checked);
    if (errors == 0) begin
      $display("tb_direct_complex_dft_core OK");
    end else begin
      $display("tb_direct_complex_dft_core NOT OK");
    end
    $finish;
  end

endmodule
